FILE: rtl/fbem_pkg.sv
package fbem_pkg;

  localparam int DEF_MAX_BLOCK    = 4096;
  localparam int DEF_MAX_CHANNELS = 2;

  localparam logic [15:0] RST_LOW_COEF      = 16'd1477;
  localparam logic [15:0] RST_LOWMID_COEF   = 16'd7060;
  localparam logic [15:0] RST_PRESENCE_COEF = 16'd28472;
  localparam logic [1:0]  RST_CHANNEL_COUNT = 2'd2;

  typedef enum logic [1:0] {
    REG_LOW_COEF      = 2'd0,
    REG_LOWMID_COEF   = 2'd1,
    REG_PRESENCE_COEF = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               block_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] low_level;
    logic [15:0] lowmid_level;
    logic [15:0] presence_level;
    logic [15:0] air_level;
  } out_item_t;

  // A finished block handed from the front to the back: four sums and the count.
  typedef struct packed {
    logic [63:0] sum0;
    logic [63:0] sum1;
    logic [63:0] sum2;
    logic [63:0] sum3;
    logic [16:0] count;
  } block_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_CMP,
    BK_DONE
  } back_state_t;

endpackage

FILE: rtl/fbem_front.sv
module fbem_front #(
  parameter int MAX_BLOCK    = fbem_pkg::DEF_MAX_BLOCK,
  parameter int MAX_CHANNELS = fbem_pkg::DEF_MAX_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  fbem_pkg::in_item_t   in_item,
  output logic                 in_ready,
  input  logic [15:0]          low_coef,
  input  logic [15:0]          lowmid_coef,
  input  logic [15:0]          presence_coef,
  input  logic [1:0]           channel_count,
  output logic                 job_valid,
  output fbem_pkg::block_job_t job,
  input  logic                 job_full
);
  import fbem_pkg::*;

  localparam int CW = $clog2(MAX_BLOCK + 1);

  // Stage 1: mono and the three filter differences; stage 2: filter products and
  // adds, bands; stage 3: squares; stage 4: accumulate.
  logic               s1_v, s2_v, s3_v;
  logic               s1_last, s2_last, s3_last;
  logic signed [24:0] s1_mono;
  logic signed [24:0] s1_d0, s1_d1, s1_d2;
  logic [15:0]        s1_c0, s1_c1, s1_c2;
  logic signed [23:0] f0, f1, f2;
  logic signed [25:0] s2_b0, s2_b1, s2_b2, s2_b3;
  logic [63:0]        s3_q0, s3_q1, s3_q2, s3_q3;
  logic [63:0]        sum0, sum1, sum2, sum3;
  logic [CW-1:0]      cnt;

  // The filter state feeds back each sample, so one sample is in the filter
  // stages at a time; the front takes no new item while one is in stage 1.
  // A new sample waits while the job queue is full or a block end is still
  // on its way to the queue, so every finished block finds a free slot.
  logic busy;
  assign in_ready = !busy && !s1_v && !job_full && !(s2_v && s2_last) &&
                    !(s3_v && s3_last);

  logic signed [23:0] mono24;
  logic               two;
  always_comb begin
    two = (channel_count >= 2'd2) && (MAX_CHANNELS >= 2);
    if (two) begin
      mono24 = 24'((25'(in_item.left_sample) + 25'(in_item.right_sample)) <<< 7);
    end else begin
      mono24 = {in_item.left_sample, 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    s1_mono <= 25'(mono24);
    s1_d0   <= 25'(mono24) - 25'(f0);
    s1_d1   <= 25'(mono24) - 25'(f1);
    s1_d2   <= 25'(mono24) - 25'(f2);
    s1_c0   <= low_coef;
    s1_c1   <= lowmid_coef;
    s1_c2   <= presence_coef;
    s1_last <= in_item.block_end;
  end

  function automatic logic signed [23:0] upd(input logic signed [23:0] st,
                                             input logic signed [24:0] d,
                                             input logic [15:0] c);
    logic signed [42:0] p;
    logic signed [43:0] n;
    begin
      p = 43'(d) * $signed({1'b0, c});
      n = 44'(st) + 44'((p + 43'sd32768) >>> 16);
      if (n > 44'sd8388607) upd = 24'sd8388607;
      else if (n < -44'sd8388608) upd = -24'sd8388608;
      else upd = n[23:0];
    end
  endfunction

  logic signed [23:0] n0, n1, n2;
  assign n0 = upd(f0, s1_d0, s1_c0);
  assign n1 = upd(f1, s1_d1, s1_c1);
  assign n2 = upd(f2, s1_d2, s1_c2);

  always_ff @(posedge clk) begin
    if (rst) begin
      f0 <= '0; f1 <= '0; f2 <= '0;
    end else if (s1_v) begin
      f0 <= n0; f1 <= n1; f2 <= n2;
    end
  end

  always_ff @(posedge clk) begin
    s2_b0   <= 26'(n0);
    s2_b1   <= 26'(n1) - 26'(n0);
    s2_b2   <= 26'(n2) - 26'(n1);
    s2_b3   <= 26'(s1_mono) - 26'(n2);
    s2_last <= s1_last;
    s3_q0   <= 64'(unsigned'(52'(s2_b0 * s2_b0)));
    s3_q1   <= 64'(unsigned'(52'(s2_b1 * s2_b1)));
    s3_q2   <= 64'(unsigned'(52'(s2_b2 * s2_b2)));
    s3_q3   <= 64'(unsigned'(52'(s2_b3 * s2_b3)));
    s3_last <= s2_last;
  end

  logic          take;
  logic [63:0]   a0, a1, a2, a3;
  logic [CW-1:0] cn;
  always_comb begin
    take = cnt < CW'(MAX_BLOCK);
    a0 = take ? sum0 + s3_q0 : sum0;
    a1 = take ? sum1 + s3_q1 : sum1;
    a2 = take ? sum2 + s3_q2 : sum2;
    a3 = take ? sum3 + s3_q3 : sum3;
    cn = take ? cnt + 1'b1 : cnt;
    job.sum0 = a0; job.sum1 = a1; job.sum2 = a2; job.sum3 = a3;
    job.count = 17'(cn);
    job_valid = s3_v && s3_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; busy <= 1'b0;
      sum0 <= '0; sum1 <= '0; sum2 <= '0; sum3 <= '0; cnt <= '0;
    end else begin
      s1_v <= in_valid && in_ready;
      busy <= in_valid && in_ready;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (s3_v) begin
        if (s3_last) begin
          sum0 <= '0; sum1 <= '0; sum2 <= '0; sum3 <= '0; cnt <= '0;
        end else begin
          sum0 <= a0; sum1 <= a1; sum2 <= a2; sum3 <= a3; cnt <= cn;
        end
      end
    end
  end

endmodule

FILE: rtl/fbem_queue.sv
module fbem_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  fbem_pkg::block_job_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output fbem_pkg::block_job_t rd_data,
  output logic                 rd_valid
);
  import fbem_pkg::*;

  block_job_t mem [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign full     = fill == 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= '0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      fill <= fill + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

FILE: rtl/fbem_back.sv
module fbem_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  fbem_pkg::block_job_t job,
  output logic                 job_take,
  output logic                 empty,
  input  logic                 pop,
  output fbem_pkg::out_item_t  result
);
  import fbem_pkg::*;

  back_state_t state, state_next;
  logic [63:0] sums [4];
  logic [16:0] count;
  logic [15:0] y [4];
  logic [15:0] bitm;
  logic [1:0]  band;
  logic [31:0] sqr;
  logic [63:0] prod;
  logic        have;

  // Each root bit of a band takes two states, BK_MUL and BK_CMP: square, then scale and compare.
  // Bands run in turn, from the low band to the air band.
  logic [15:0] t;
  assign t = y[band] | bitm;

  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    unique case (state)
      BK_IDLE: if (job_valid) begin
        job_take = 1'b1;
        state_next = BK_MUL;
      end
      BK_MUL:  state_next = BK_CMP;
      BK_CMP:  if (bitm == 16'd1 && band == 2'd3) state_next = BK_DONE;
               else state_next = BK_MUL;
      BK_DONE: if (!have) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (state == BK_DONE && !have) begin
      have <= 1'b1;
    end else if (pop && have) begin
      have <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        sums[0] <= job.sum0; sums[1] <= job.sum1;
        sums[2] <= job.sum2; sums[3] <= job.sum3;
        count <= job.count;
        for (int i = 0; i < 4; i++) y[i] <= '0;
        bitm <= 16'h8000;
        band <= '0;
      end
      BK_MUL: sqr <= t * t;
      BK_CMP: begin
        if (prod <= sums[band]) y[band] <= t;
        if (bitm == 16'd1) begin
          bitm <= 16'h8000;
          band <= band + 2'd1;
        end else begin
          bitm <= bitm >> 1;
        end
      end
      BK_DONE: if (!have) begin
        result.low_level      <= y[0];
        result.lowmid_level   <= y[1];
        result.presence_level <= y[2];
        result.air_level      <= y[3];
      end
      default: ;
    endcase
  end

  assign prod  = ({22'd0, sqr, 10'd0}) * {47'd0, count};
  assign empty = !have;

endmodule

FILE: rtl/four_band_energy_meter_top.sv
// The input takes no new sample while the last one is still in the first filter
// stage, as the filter state feeds back each sample. The shared root unit works
// out the four bands of a block in turn, bit by bit; when blocks come faster than
// it finishes them, the queue fills and the input stalls.
// Synchronous active-high rst clears filters, sums, count, queue and the waiting
// result; coefficients and the channel count return to their defaults.
module four_band_energy_meter_top #(
  parameter int MAX_BLOCK    = fbem_pkg::DEF_MAX_BLOCK,
  parameter int MAX_CHANNELS = fbem_pkg::DEF_MAX_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fbem_pkg::in_item_t  in_item,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output fbem_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import fbem_pkg::*;

  logic [15:0] low_coef, lowmid_coef, presence_coef;
  logic [1:0]  channel_count;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      low_coef <= RST_LOW_COEF;
      lowmid_coef <= RST_LOWMID_COEF;
      presence_coef <= RST_PRESENCE_COEF;
      channel_count <= RST_CHANNEL_COUNT;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_LOW_COEF:      low_coef <= cfg_data;
        REG_LOWMID_COEF:   lowmid_coef <= cfg_data;
        REG_PRESENCE_COEF: presence_coef <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic       in_ready, jv, jfull, jtake, qv;
  block_job_t jd, qd;
  assign full = !in_ready;

  fbem_front #(.MAX_BLOCK(MAX_BLOCK), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk, .rst, .in_valid(push), .in_item, .in_ready,
    .low_coef, .lowmid_coef, .presence_coef, .channel_count,
    .job_valid(jv), .job(jd), .job_full(jfull)
  );

  fbem_queue u_queue (
    .clk, .rst, .wr_en(jv), .wr_data(jd), .full(jfull),
    .rd_en(jtake), .rd_data(qd), .rd_valid(qv)
  );

  fbem_back u_back (
    .clk, .rst, .job_valid(qv), .job(qd), .job_take(jtake),
    .empty, .pop, .result(out_item)
  );

endmodule

FILE: rtl/four_band_energy_meter_checker.sv
module four_band_energy_meter_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input fbem_pkg::out_item_t out_item
);
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed");
  a_no_back: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("two samples accepted in consecutive cycles");
endmodule

bind four_band_energy_meter_top four_band_energy_meter_checker u_chk (
  .clk, .rst, .push, .full, .empty, .pop, .out_item
);
